### rtl/tked_pkg.sv
`timescale 1ns / 1ps

package tked_pkg;

   // link bytes with a meaning of their own
   localparam logic [7:0] BYTE_ETX   = 8'h03;
   localparam logic [7:0] BYTE_EOT   = 8'h04;
   localparam logic [7:0] BYTE_CR    = 8'h0D;
   localparam logic [7:0] BYTE_ESC   = 8'h1B;
   localparam logic [7:0] BYTE_CSI   = 8'h5B;
   localparam logic [7:0] BYTE_SS3   = 8'h4F;
   localparam logic [7:0] BYTE_TILDE = 8'h7E;
   localparam logic [7:0] BYTE_DEL   = 8'h7F;
   localparam logic [7:0] BYTE_SPACE = 8'h20;

   // key kinds
   localparam logic [4:0] KEY_PRINT = 5'd0;
   localparam logic [4:0] KEY_BS    = 5'd1;
   localparam logic [4:0] KEY_RET   = 5'd2;
   localparam logic [4:0] KEY_CTRLC = 5'd3;
   localparam logic [4:0] KEY_CTRLD = 5'd4;
   localparam logic [4:0] KEY_UP    = 5'd5;
   localparam logic [4:0] KEY_DOWN  = 5'd6;
   localparam logic [4:0] KEY_RIGHT = 5'd7;
   localparam logic [4:0] KEY_LEFT  = 5'd8;
   localparam logic [4:0] KEY_F1    = 5'd9;
   localparam logic [4:0] KEY_F2    = 5'd10;
   localparam logic [4:0] KEY_F3    = 5'd11;
   localparam logic [4:0] KEY_F4    = 5'd12;
   localparam logic [4:0] KEY_F5    = 5'd13;
   localparam logic [4:0] KEY_F6    = 5'd14;
   localparam logic [4:0] KEY_F7    = 5'd15;
   localparam logic [4:0] KEY_F8    = 5'd16;
   localparam logic [4:0] KEY_F9    = 5'd17;
   localparam logic [4:0] KEY_F10   = 5'd18;
   localparam logic [4:0] KEY_F11   = 5'd19;
   localparam logic [4:0] KEY_F12   = 5'd20;
   localparam logic [4:0] KEY_DELETE = 5'd21;
   localparam logic [4:0] KEY_PGUP  = 5'd22;
   localparam logic [4:0] KEY_PGDN  = 5'd23;

   // decoder result for one byte
   typedef struct packed {
      logic       hit;
      logic [4:0] key_kind;
      logic [6:0] char_code;
   } tked_event_type;

endpackage

### rtl/tked_if.sv
`timescale 1ns / 1ps

interface tked_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface tked_rsp_if;
   logic       valid;
   logic       ready;
   logic [4:0] key_kind;
   logic [6:0] char_code;

   modport source (output valid, output key_kind, output char_code, input ready);
   modport sink   (input valid, input key_kind, input char_code, output ready);
endinterface

### rtl/tked_in_stage.sv
`timescale 1ns / 1ps

module tked_in_stage
   import tked_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   tked_req_if.sink    req_link,
   input  logic        advance,
   output logic        stage_valid,
   output logic [7:0]  stage_byte
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic       take;

   assign req_link.ready = !valid_ff || advance;
   assign take           = req_link.valid && req_link.ready;
   assign valid_in       = take || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         byte_ff <= req_link.in_byte;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_byte  = byte_ff;

endmodule

### rtl/tked_decode.sv
`timescale 1ns / 1ps

module tked_decode
   import tked_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           fire,
   input  logic [7:0]     in_byte,
   output tked_event_type key_event
);

   typedef enum logic [3:0] {
      ST_IDLE    = 4'd0,
      ST_ESC     = 4'd1,
      ST_CSI     = 4'd2,
      ST_SS3     = 4'd3,
      ST_CSI1    = 4'd4,
      ST_CSI2    = 4'd5,
      ST_CSI3    = 4'd6,
      ST_CSI5    = 4'd7,
      ST_CSI6    = 4'd8,
      ST_SWALLOW = 4'd9
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in            = ST_IDLE;
      key_event.hit       = 1'b0;
      key_event.key_kind  = KEY_PRINT;
      key_event.char_code = 7'd0;
      unique case (state_ff)
         ST_IDLE: begin
            if (in_byte >= BYTE_SPACE && in_byte < BYTE_DEL) begin
               key_event.hit       = 1'b1;
               key_event.char_code = in_byte[6:0];
            end else if (in_byte == BYTE_DEL) begin
               key_event.hit      = 1'b1;
               key_event.key_kind = KEY_BS;
            end else if (in_byte == BYTE_CR) begin
               key_event.hit      = 1'b1;
               key_event.key_kind = KEY_RET;
            end else if (in_byte == BYTE_ETX) begin
               key_event.hit      = 1'b1;
               key_event.key_kind = KEY_CTRLC;
            end else if (in_byte == BYTE_EOT) begin
               key_event.hit      = 1'b1;
               key_event.key_kind = KEY_CTRLD;
            end else if (in_byte == BYTE_ESC) begin
               state_in = ST_ESC;
            end
         end
         ST_ESC: begin
            if (in_byte == BYTE_CSI) begin
               state_in = ST_CSI;
            end else if (in_byte == BYTE_SS3) begin
               state_in = ST_SS3;
            end
         end
         ST_CSI: begin
            unique case (in_byte)
               8'h41: begin key_event.hit = 1'b1; key_event.key_kind = KEY_UP;    end
               8'h42: begin key_event.hit = 1'b1; key_event.key_kind = KEY_DOWN;  end
               8'h43: begin key_event.hit = 1'b1; key_event.key_kind = KEY_RIGHT; end
               8'h44: begin key_event.hit = 1'b1; key_event.key_kind = KEY_LEFT;  end
               8'h31: state_in = ST_CSI1;
               8'h32: state_in = ST_CSI2;
               8'h33: state_in = ST_CSI3;
               8'h35: state_in = ST_CSI5;
               8'h36: state_in = ST_CSI6;
               default: state_in = ST_IDLE;
            endcase
         end
         ST_SS3: begin
            unique case (in_byte)
               8'h50: begin key_event.hit = 1'b1; key_event.key_kind = KEY_F1; end
               8'h51: begin key_event.hit = 1'b1; key_event.key_kind = KEY_F2; end
               8'h52: begin key_event.hit = 1'b1; key_event.key_kind = KEY_F3; end
               8'h53: begin key_event.hit = 1'b1; key_event.key_kind = KEY_F4; end
               default: key_event.hit = 1'b0;
            endcase
         end
         ST_CSI1: begin
            state_in = ST_SWALLOW;
            unique case (in_byte)
               8'h35: begin key_event.hit = 1'b1; key_event.key_kind = KEY_F5; end
               8'h37: begin key_event.hit = 1'b1; key_event.key_kind = KEY_F6; end
               8'h38: begin key_event.hit = 1'b1; key_event.key_kind = KEY_F7; end
               8'h39: begin key_event.hit = 1'b1; key_event.key_kind = KEY_F8; end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_CSI2: begin
            state_in = ST_SWALLOW;
            unique case (in_byte)
               8'h30: begin key_event.hit = 1'b1; key_event.key_kind = KEY_F9;  end
               8'h31: begin key_event.hit = 1'b1; key_event.key_kind = KEY_F10; end
               8'h33: begin key_event.hit = 1'b1; key_event.key_kind = KEY_F11; end
               8'h34: begin key_event.hit = 1'b1; key_event.key_kind = KEY_F12; end
               default: state_in = ST_IDLE;
            endcase
         end
         ST_CSI3: begin
            if (in_byte == BYTE_TILDE) begin
               key_event.hit      = 1'b1;
               key_event.key_kind = KEY_DELETE;
            end
         end
         ST_CSI5: begin
            if (in_byte == BYTE_TILDE) begin
               key_event.hit      = 1'b1;
               key_event.key_kind = KEY_PGUP;
            end
         end
         ST_CSI6: begin
            if (in_byte == BYTE_TILDE) begin
               key_event.hit      = 1'b1;
               key_event.key_kind = KEY_PGDN;
            end
         end
         // swallowed byte, and any stray code, goes back to idle
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else if (fire) begin
         state_ff <= state_in;
      end
   end

   // function keys five to twelve always leave the trailing byte to swallow
   a_fkey_swallow: assert property (@(posedge clock) disable iff (reset)
      fire && key_event.hit && key_event.key_kind >= KEY_F5 && key_event.key_kind <= KEY_F12
      |=> state_ff == ST_SWALLOW)
      else $error("function key did not arm swallow");

   // a swallowed byte never yields an event
   a_swallow_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SWALLOW |-> !key_event.hit)
      else $error("event raised on swallowed byte");

endmodule

### rtl/tked_out_stage.sv
`timescale 1ns / 1ps

module tked_out_stage
   import tked_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           load,
   input  tked_event_type key_event,
   output logic           out_free,
   tked_rsp_if.source     rsp_link
);

   logic       valid_ff;
   logic       valid_in;
   logic [4:0] kind_ff;
   logic [6:0] code_ff;

   assign out_free = !valid_ff || rsp_link.ready;
   assign valid_in = load || (valid_ff && !rsp_link.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         kind_ff <= key_event.key_kind;
         code_ff <= key_event.char_code;
      end
   end

   assign rsp_link.valid     = valid_ff;
   assign rsp_link.key_kind  = kind_ff;
   assign rsp_link.char_code = code_ff;

endmodule

### rtl/terminal_key_escape_decoder.sv
`timescale 1ns / 1ps
// a request word passes the input register, then the result register, to the response side
// throughput: one byte per cycle unless stalled, set by the decoder's single parse-state
// register loop; bytes that end or step a sequence without a key give no response word at all
// reset (synchronous, active high) empties both word registers and returns the parser to idle

module terminal_key_escape_decoder
   import tked_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   tked_req_if.sink   req_link,
   tked_rsp_if.source rsp_link
);

   // input register stage outputs
   logic           stage_valid;
   logic [7:0]     stage_byte;

   // decode handshake
   logic           out_free;
   logic           fire;
   tked_event_type key_event;

   // a byte leaves the input register whenever the result register can take a word,
   // so the parser steps once per byte and a key is loaded in the same cycle
   assign fire = stage_valid && out_free;

   tked_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_link    (req_link),
      .advance     (fire),
      .stage_valid (stage_valid),
      .stage_byte  (stage_byte)
   );

   // parse state and key lookup
   tked_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .in_byte   (stage_byte),
      .key_event (key_event)
   );

   // result register, parts the two handshakes
   tked_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (fire && key_event.hit),
      .key_event (key_event),
      .out_free  (out_free),
      .rsp_link  (rsp_link)
   );

   // only printable keys carry a character code
   a_char_only_print: assert property (@(posedge clock) disable iff (reset)
      rsp_link.valid && rsp_link.key_kind != KEY_PRINT |-> rsp_link.char_code == 7'd0)
      else $error("character code on non-printable key");

   // a fresh response word must come from a byte that was waiting in the input register
   a_rsp_from_stage: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_link.valid) |-> $past(stage_valid))
      else $error("response word without a staged byte");

   // key kind stays within the defined set
   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_link.valid |-> rsp_link.key_kind <= KEY_PGDN)
      else $error("key kind out of range");

endmodule
